/* hw/rtl/ucp_pkg.sv */
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared widths and transaction types for the unit cross product block.
// ----------------------------------------------------------------------------
`default_nettype none

package ucp_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;

    localparam int PROD_W  = 2 * IN_WIDTH;     // one component product
    localparam int CROSS_W = PROD_W + 1;       // cross product component
    localparam int MAG_W   = PROD_W;           // |component|
    localparam int SUM_W   = 2 * MAG_W;        // sum of squares
    localparam int ROOT_W  = MAG_W;            // floor square root
    localparam int REM_W   = ROOT_W + 3;       // square root remainder
    localparam int QUO_W   = OUT_FRAC_BITS + 1;// quotient magnitude

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] a_x;
        logic signed [IN_WIDTH-1:0] a_y;
        logic signed [IN_WIDTH-1:0] a_z;
        logic signed [IN_WIDTH-1:0] b_x;
        logic signed [IN_WIDTH-1:0] b_y;
        logic signed [IN_WIDTH-1:0] b_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] n_x;
        logic signed [OUT_WIDTH-1:0] n_y;
        logic signed [OUT_WIDTH-1:0] n_z;
        logic                        zero_cross;
    } out_t;

    // Square root chain payload
    typedef struct packed {
        logic [SUM_W-1:0]          rad;
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic [2:0][MAG_W-1:0]     u;
        logic [2:0]                sgn;
    } sqrt_t;

    // Division chain payload, three lanes sharing one divisor
    typedef struct packed {
        logic [ROOT_W-1:0]         mag;
        logic [2:0][ROOT_W-1:0]    r;
        logic [2:0]                fb;
        logic [2:0][QUO_W-1:0]     q;
        logic [2:0]                sgn;
        logic                      zero;
    } div_t;

endpackage

`default_nettype wire

/* hw/rtl/unit_cross_product_3d.sv */
// ----------------------------------------------------------------------------
// unit_cross_product_3d
// Unit normal of two 3D vectors: normalised cross product in signed Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one transaction per cycle unless stalled, with vectors A and B (Q7.8).
//   m_* returns one transaction per input: n = (A x B) / floor(|A x B|)
//   in signed Q1.14, truncated toward zero. A zero cross product gives
//   zero_cross = 1 and an all-zero normal.
//   Pipeline: 4 front stages (products, differences, squares, sum),
//   ROOT_W square root cells (one root bit each), QUO_W division cells
//   (one quotient bit each) and the output register.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the whole cell chain moves as one pipeline.
//   Stall: while m_valid is high and m_ready low, the chain freezes and
//   s_ready drops in the same cycle; nothing is lost or repeated.
//   Reset: aresetn (synchronous, active low) clears all valid bits; data
//   registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module unit_cross_product_3d
    import ucp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic  adv;
    logic  m_valid_reg;
    out_t  m_data_reg, m_data_next;

    // Square root chain: index 0 is the front end output
    logic  sq_v [ROOT_W+1];
    sqrt_t sq_d [ROOT_W+1];

    // Division chain: index 0 is fed from the last root cell
    logic  dv_v [QUO_W+1];
    div_t  dv_d [QUO_W+1];

    // Whole chain advances whenever the output slot is free or being taken
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    ucp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (sq_v[0]),
        .out_data  (sq_d[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        ucp_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_v[g]),
            .in_data   (sq_d[g]),
            .out_valid (sq_v[g+1]),
            .out_data  (sq_d[g+1])
        );
    end

    // Hand-over: quotient magnitude never exceeds 2^frac, so the first
    // remainder is |c| >> 1 and the bit shifted in first is |c|[0].
    always_comb begin
        dv_v[0]      = sq_v[ROOT_W];
        dv_d[0].mag  = sq_d[ROOT_W].root;
        dv_d[0].zero = (sq_d[ROOT_W].root == '0);
        dv_d[0].sgn  = sq_d[ROOT_W].sgn;
        dv_d[0].q    = '0;
        for (int i = 0; i < 3; i++) begin
            dv_d[0].r[i]  = ROOT_W'(sq_d[ROOT_W].u[i] >> 1);
            dv_d[0].fb[i] = sq_d[ROOT_W].u[i][0];
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        ucp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (dv_v[g]),
            .in_data   (dv_d[g]),
            .out_valid (dv_v[g+1]),
            .out_data  (dv_d[g+1])
        );
    end

    // Sign restore and zero override
    always_comb begin
        m_data_next.zero_cross = dv_d[QUO_W].zero;
        if (dv_d[QUO_W].zero) begin
            m_data_next.n_x = '0;
            m_data_next.n_y = '0;
            m_data_next.n_z = '0;
        end else begin
            m_data_next.n_x = dv_d[QUO_W].sgn[0] ? -OUT_WIDTH'(dv_d[QUO_W].q[0])
                                                 :  OUT_WIDTH'(dv_d[QUO_W].q[0]);
            m_data_next.n_y = dv_d[QUO_W].sgn[1] ? -OUT_WIDTH'(dv_d[QUO_W].q[1])
                                                 :  OUT_WIDTH'(dv_d[QUO_W].q[1]);
            m_data_next.n_z = dv_d[QUO_W].sgn[2] ? -OUT_WIDTH'(dv_d[QUO_W].q[2])
                                                 :  OUT_WIDTH'(dv_d[QUO_W].q[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_v[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A zero flag always comes with an all-zero normal
    a_zero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_cross |->
            m_data.n_x == '0 && m_data.n_y == '0 && m_data.n_z == '0)
        else $error("zero_cross with non-zero normal");

    // A non-zero cross product has at least one non-zero component
    a_nonzero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_cross |->
            m_data.n_x != '0 || m_data.n_y != '0 || m_data.n_z != '0)
        else $error("non-zero cross product gave an all-zero normal");

    // The x component stays within +-1.0
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            $signed(m_data.n_x) <= $signed(OUT_WIDTH'(1 << OUT_FRAC_BITS)) &&
            $signed(m_data.n_x) >= -$signed(OUT_WIDTH'(1 << OUT_FRAC_BITS)))
        else $error("n_x out of unit range");

    // The chain freezes while the output is stalled
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(dv_v[QUO_W]))
        else $error("chain moved while output stalled");

endmodule

`default_nettype wire

/* hw/rtl/ucp_front.sv */
// ----------------------------------------------------------------------------
// ucp_front
// Cross product, magnitudes, squares and sum of squares in four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_front
    import ucp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire in_t   in_data,
    output logic       out_valid,
    output sqrt_t      out_data
);

    logic [3:0] valid_reg;

    logic signed [PROD_W-1:0] p_reg [6];
    logic signed [CROSS_W-1:0] c_next [3];
    logic [2:0][MAG_W-1:0]    u_reg, u_next;
    logic [2:0]               sgn_reg, sgn_next, sgn2_reg;
    logic [2:0][MAG_W-1:0]    u2_reg;
    logic [2:0][SUM_W-1:0]    sq_reg;
    sqrt_t                    out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_comb begin
        c_next[0] = CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
        c_next[1] = CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
        c_next[2] = CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
        for (int i = 0; i < 3; i++) begin
            sgn_next[i] = c_next[i][CROSS_W-1];
            u_next[i]   = sgn_next[i] ? MAG_W'(-c_next[i]) : MAG_W'(c_next[i]);
        end
        out_next.rad  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        out_next.rem  = '0;
        out_next.root = '0;
        out_next.u    = u2_reg;
        out_next.sgn  = sgn2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= in_data.a_y * in_data.b_z;
            p_reg[1] <= in_data.a_z * in_data.b_y;
            p_reg[2] <= in_data.a_z * in_data.b_x;
            p_reg[3] <= in_data.a_x * in_data.b_z;
            p_reg[4] <= in_data.a_x * in_data.b_y;
            p_reg[5] <= in_data.a_y * in_data.b_x;
            u_reg    <= u_next;
            sgn_reg  <= sgn_next;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SUM_W'(u_reg[i]) * SUM_W'(u_reg[i]);
            end
            u2_reg   <= u_reg;
            sgn2_reg <= sgn_reg;
            out_reg  <= out_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/ucp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ucp_sqrt_cell
// One root bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_sqrt_cell
    import ucp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire sqrt_t in_data,
    output logic       out_valid,
    output sqrt_t      out_data
);

    logic       valid_reg;
    sqrt_t      data_reg, data_next;
    logic [REM_W-1:0] rem_sh, trial;

    always_comb begin
        rem_sh    = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1 -: 2]};
        trial     = {1'b0, in_data.root, 2'b01};
        data_next = in_data;
        data_next.rad = {in_data.rad[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_sh;
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/ucp_div_cell.sv */
// ----------------------------------------------------------------------------
// ucp_div_cell
// One quotient bit of restoring division, three lanes over one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_div_cell
    import ucp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire div_t in_data,
    output logic      out_valid,
    output div_t      out_data
);

    logic       valid_reg;
    div_t       data_reg, data_next;
    logic [ROOT_W:0] r2 [3];
    logic [ROOT_W:0] magx;

    always_comb begin
        data_next = in_data;
        magx      = {1'b0, in_data.mag};
        for (int i = 0; i < 3; i++) begin
            r2[i] = {in_data.r[i], in_data.fb[i]};
            if (r2[i] >= magx) begin
                data_next.r[i] = ROOT_W'(r2[i] - magx);
                data_next.q[i] = {in_data.q[i][QUO_W-2:0], 1'b1};
            end else begin
                data_next.r[i] = ROOT_W'(r2[i]);
                data_next.q[i] = {in_data.q[i][QUO_W-2:0], 1'b0};
            end
        end
        data_next.fb = 3'b000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* sim/unit_cross_product_3d_tb.sv */
// ----------------------------------------------------------------------------
// unit_cross_product_3d_tb
// Self-checking bench: predicts each unit normal from the input vectors and
// checks every result transaction in order, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module unit_cross_product_3d_tb
    import ucp_pkg::*;
();

    localparam int LATENCY   = 52;
    localparam int WDOG_MAX  = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t normal_q[$];          // expected normals, oldest first
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;      // long receiver stall request
    bit   no_gaps = 1'b0;       // sender runs without idling

    always #5 aclk = ~aclk;

    unit_cross_product_3d i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] scale_axis(longint c, longint unsigned mag);
        longint unsigned a, q;
        a = (c < 0) ? -c : c;
        q = (a << OUT_FRAC_BITS) / mag;
        if (c < 0) q = -q;
        return q[OUT_WIDTH-1:0];
    endfunction

    function automatic out_t unit_normal(in_t v);
        longint cx, cy, cz;
        longint unsigned mag;
        out_t r;
        cx = longint'(v.a_y) * v.b_z - longint'(v.a_z) * v.b_y;
        cy = longint'(v.a_z) * v.b_x - longint'(v.a_x) * v.b_z;
        cz = longint'(v.a_x) * v.b_y - longint'(v.a_y) * v.b_x;
        mag = floor_sqrt(longint'(cx * cx) + cx * 0 + cy * cy + cz * cz);
        r = '0;
        if (mag == 0) begin
            r.zero_cross = 1'b1;
        end else begin
            r.n_x = scale_axis(cx, mag);
            r.n_y = scale_axis(cy, mag);
            r.n_z = scale_axis(cz, mag);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Send one transaction; valid held until accepted
    task automatic send_vectors(in_t v);
        s_data  <= v;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        normal_q.push_back(unit_normal(v));
        @(negedge aclk);
    endtask

    // Valid only drops when a gap is actually taken
    task automatic sender_gap();
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    function automatic in_t rand_vectors();
        in_t v;
        int  mode;
        v = {$urandom, $urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            v.b_x = v.a_x; v.b_y = v.a_y; v.b_z = v.a_z;      // parallel
        end else if (mode == 1) begin
            v.b_x = -v.a_x; v.b_y = -v.a_y; v.b_z = -v.a_z;   // antiparallel
        end else if (mode == 2) begin
            v.a_x = $signed(16'($urandom_range(0, 15))) - 16'sd8;  // short vectors
            v.a_y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            v.a_z = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        end
        return v;
    endfunction

    // Receiver: own stall pattern, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 7) != 0) || $urandom_range(0, 1);
    end

    // Result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (normal_q.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = normal_q.pop_front();
                if (m_data.n_x !== want.n_x) report_mismatch("n_x", m_data.n_x, want.n_x);
                if (m_data.n_y !== want.n_y) report_mismatch("n_y", m_data.n_y, want.n_y);
                if (m_data.n_z !== want.n_z) report_mismatch("n_z", m_data.n_z, want.n_z);
                if (m_data.zero_cross !== want.zero_cross)
                    report_mismatch("zero_cross", m_data.zero_cross, want.zero_cross);
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sender goes idle and waits for every expected result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (normal_q.size() != 0) @(negedge aclk);
    endtask

    // Extremes, zero vectors, parallel pairs, axis-aligned results
    task automatic test_directed();
        localparam logic signed [15:0] MX = 16'sh7FFF, MN = -16'sh8000;
        in_t v[$];
        v.push_back('{0, 0, 0, 0, 0, 0});
        v.push_back('{256, 0, 0, 0, 256, 0});          // z axis
        v.push_back('{0, 256, 0, 0, 0, 256});          // x axis
        v.push_back('{0, 0, 256, 256, 0, 0});          // y axis
        v.push_back('{0, 256, 0, 256, 0, 0});          // -z axis
        v.push_back('{MX, MX, MX, MX, MX, MX});        // parallel
        v.push_back('{MN, MN, MN, MX, MX, MX});
        v.push_back('{MN, 0, 0, 0, MN, 0});
        v.push_back('{MX, MN, MX, MN, MX, MN});
        v.push_back('{MN, MX, 0, MX, MN, MN});
        v.push_back('{MN, MN, MN, MN, MX, MN});
        v.push_back('{MX, 0, 0, 0, MX, 0});
        v.push_back('{-1, -1, -1, 1, 1, -1});
        v.push_back('{1, 0, 0, 0, 1, 0});
        v.push_back('{1, 2, 3, 0, 0, 0});
        v.push_back('{0, 0, 0, MN, MX, 5});
        v.push_back('{1, 1, 0, 1, -1, 0});
        v.push_back('{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1});
        v.push_back('{MX, MX, 0, MX, MN, 0});
        v.push_back('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
        foreach (v[i]) begin
            send_vectors(v[i]);
            sender_gap();
        end
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            send_vectors(rand_vectors());
            sender_gap();
        end
    endtask

    // Receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                no_gaps = 1'b1;
                test_random(200);
                no_gaps = 1'b0;
            end
        join
        wait_drained();                                // sender pauses
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(800);
        test_backpressure();
        no_gaps = 1'b1;
        test_random(400);                              // back-to-back stretch
        no_gaps = 1'b0;
        test_random(600);

        wait_drained();
        repeat (LATENCY + 10) @(negedge aclk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
